FILE: sv/assert_macros.svh
// assertion macros used by the list engine core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sle assertion failed");

// next-cycle implication, disabled while reset is low
`define SLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sle assertion failed");

`endif

FILE: sv/sle_pkg.sv
// types, constants and microprogram of the sequential list engine
package sle_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_READ   = 3'd3,
        OP_LOCATE = 3'd4,
        OP_PRIOR  = 3'd5,
        OP_NEXT   = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_NOT_FOUND    = 3'd1,
        STAT_BAD_POS      = 3'd2,
        STAT_FULL         = 3'd3,
        STAT_NO_NEIGHBOUR = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_POS_GT_LEN,
        C_POS_GE_LEN,
        C_LEN_FULL,
        C_IDX_LE_POS,
        C_IDX_P1_GE_LEN,
        C_IDX_GE_LEN,
        C_MATCH,
        C_IDX_ZERO,
        C_OP_LOCATE,
        C_OP_NEXT
    } t_cond;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1,
        RD_POS
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_IDX_RDATA,
        WR_POS_VAL
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LEN,
        IDX_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LEN_CLR,
        ACT_LEN_INC,
        ACT_LEN_DEC,
        ACT_VOUT,
        ACT_POUT,
        ACT_STATUS
    } t_act;

    typedef logic [4:0] t_step;

    typedef struct packed {
        t_cond   cond;
        t_step   target;
        t_rd_sel rd;
        t_wr_sel wr;
        t_idx_op idx;
        t_act    act;
        t_status status;
        logic    done;
    } t_uword;

    typedef struct packed {
        logic pos_gt_len;
        logic pos_ge_len;
        logic len_full;
        logic idx_le_pos;
        logic idx_p1_ge_len;
        logic idx_ge_len;
        logic match;
        logic idx_zero;
        logic op_locate;
        logic op_next;
    } t_flags;

    // program entry points and shared steps
    localparam t_step S_CLEAR     = 5'd0;
    localparam t_step S_INS_CHK   = 5'd1;
    localparam t_step S_INS_FULL  = 5'd2;
    localparam t_step S_INS_LOOP  = 5'd3;
    localparam t_step S_INS_MOVE  = 5'd4;
    localparam t_step S_INS_PUT   = 5'd5;
    localparam t_step S_DEL_CHK   = 5'd6;
    localparam t_step S_DEL_TAKE  = 5'd7;
    localparam t_step S_DEL_LOOP  = 5'd8;
    localparam t_step S_DEL_MOVE  = 5'd9;
    localparam t_step S_DEL_END   = 5'd10;
    localparam t_step S_RD_CHK    = 5'd11;
    localparam t_step S_RD_END    = 5'd12;
    localparam t_step S_SRCH      = 5'd13;
    localparam t_step S_SRCH_RD   = 5'd14;
    localparam t_step S_SRCH_CMP  = 5'd15;
    localparam t_step S_SRCH_INC  = 5'd16;
    localparam t_step S_HIT       = 5'd17;
    localparam t_step S_HIT_KIND  = 5'd18;
    localparam t_step S_PRIOR     = 5'd19;
    localparam t_step S_PRIOR_END = 5'd20;
    localparam t_step S_NEXT      = 5'd21;
    localparam t_step S_NEXT_END  = 5'd22;
    localparam t_step S_LOC_END   = 5'd23;
    localparam t_step S_E_BAD     = 5'd24;
    localparam t_step S_E_FULL    = 5'd25;
    localparam t_step S_E_NF      = 5'd26;
    localparam t_step S_E_NN      = 5'd27;
    localparam t_step S_NOP       = 5'd28;

    function automatic t_uword mk(input t_cond c, input t_step t, input t_rd_sel r,
                                  input t_wr_sel w, input t_idx_op i, input t_act a,
                                  input t_status s, input logic d);
        t_uword u;
        u.cond   = c;
        u.target = t;
        u.rd     = r;
        u.wr     = w;
        u.idx    = i;
        u.act    = a;
        u.status = s;
        u.done   = d;
        return u;
    endfunction

    function automatic t_step entry_step(input logic [2:0] op);
        t_step s;
        unique case (op)
            OP_CLEAR:  s = S_CLEAR;
            OP_INSERT: s = S_INS_CHK;
            OP_DELETE: s = S_DEL_CHK;
            OP_READ:   s = S_RD_CHK;
            OP_LOCATE,
            OP_PRIOR,
            OP_NEXT:   s = S_SRCH;
            default:   s = S_NOP;
        endcase
        return s;
    endfunction

    // control store
    function automatic t_uword uprog(input t_step s);
        t_uword u;
        unique case (s)
            S_CLEAR:     u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_LEN_CLR, STAT_OK, 1'b1);
            S_INS_CHK:   u = mk(C_POS_GT_LEN, S_E_BAD, RD_NONE, WR_NONE, IDX_LEN,
                                ACT_NONE, STAT_OK, 1'b0);
            S_INS_FULL:  u = mk(C_LEN_FULL, S_E_FULL, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_INS_LOOP:  u = mk(C_IDX_LE_POS, S_INS_PUT, RD_IDX_M1, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_INS_MOVE:  u = mk(C_ALWAYS, S_INS_LOOP, RD_NONE, WR_IDX_RDATA, IDX_DEC,
                                ACT_NONE, STAT_OK, 1'b0);
            S_INS_PUT:   u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_POS_VAL, IDX_HOLD,
                                ACT_LEN_INC, STAT_OK, 1'b1);
            S_DEL_CHK:   u = mk(C_POS_GE_LEN, S_E_BAD, RD_POS, WR_NONE, IDX_POS,
                                ACT_NONE, STAT_OK, 1'b0);
            S_DEL_TAKE:  u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_VOUT, STAT_OK, 1'b0);
            S_DEL_LOOP:  u = mk(C_IDX_P1_GE_LEN, S_DEL_END, RD_IDX_P1, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_DEL_MOVE:  u = mk(C_ALWAYS, S_DEL_LOOP, RD_NONE, WR_IDX_RDATA, IDX_INC,
                                ACT_NONE, STAT_OK, 1'b0);
            S_DEL_END:   u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_LEN_DEC, STAT_OK, 1'b1);
            S_RD_CHK:    u = mk(C_POS_GE_LEN, S_E_BAD, RD_POS, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_RD_END:    u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_VOUT, STAT_OK, 1'b1);
            S_SRCH:      u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_ZERO,
                                ACT_NONE, STAT_OK, 1'b0);
            S_SRCH_RD:   u = mk(C_IDX_GE_LEN, S_E_NF, RD_IDX, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_SRCH_CMP:  u = mk(C_MATCH, S_HIT, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_SRCH_INC:  u = mk(C_ALWAYS, S_SRCH_RD, RD_NONE, WR_NONE, IDX_INC,
                                ACT_NONE, STAT_OK, 1'b0);
            S_HIT:       u = mk(C_OP_LOCATE, S_LOC_END, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_HIT_KIND:  u = mk(C_OP_NEXT, S_NEXT, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_PRIOR:     u = mk(C_IDX_ZERO, S_E_NN, RD_IDX_M1, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_PRIOR_END: u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_VOUT, STAT_OK, 1'b1);
            S_NEXT:      u = mk(C_IDX_P1_GE_LEN, S_E_NN, RD_IDX_P1, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b0);
            S_NEXT_END:  u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_VOUT, STAT_OK, 1'b1);
            S_LOC_END:   u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_POUT, STAT_OK, 1'b1);
            S_E_BAD:     u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_STATUS, STAT_BAD_POS, 1'b1);
            S_E_FULL:    u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_STATUS, STAT_FULL, 1'b1);
            S_E_NF:      u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_STATUS, STAT_NOT_FOUND, 1'b1);
            S_E_NN:      u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_STATUS, STAT_NO_NEIGHBOUR, 1'b1);
            default:     u = mk(C_NEXT, S_CLEAR, RD_NONE, WR_NONE, IDX_HOLD,
                                ACT_NONE, STAT_OK, 1'b1);
        endcase
        return u;
    endfunction

endpackage

FILE: sv/sequential_list_engine_core.sv
// top level of the sequential list engine: datapath, element memory and result register
// insert and delete shift every element behind the position, one read-then-write move at a time
// searches read and compare from position 0 up to the first match or the end of the list
// one request at a time; the next is taken once the sequencer is idle again, which it becomes
// at the edge that registers the result; a pending result beat holds it in its last step
// reset: synchronous, active low; clears the length, the sequencer and the result valid
`include "assert_macros.svh"

module sequential_list_engine_core
    import sle_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [6:0]         i_position_in,
    input  logic signed [31:0] i_value_in,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic [5:0]         o_position_out,
    output logic [6:0]         o_list_length_out,
    output logic               o_is_empty
);

    // length counter holds 0..DEPTH, memory address holds 0..DEPTH-1
    localparam int LW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // compare width wide enough for both the length and the position field
    localparam int PW = (LW > 7) ? LW : 7;

    // element memory, no reset: data read from unoccupied positions is never used
    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rdata;

    // request registers
    logic [2:0]    r_op;
    logic [PW-1:0] r_pos;
    logic [31:0]   r_val;

    // working state
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [LW-1:0] r_idx;
    logic [LW-1:0] n_idx;
    logic [LW-1:0] idx_m1;
    logic [LW-1:0] idx_p1;
    t_status       r_status;
    t_status       n_status;
    logic [31:0]   r_vout;
    logic [31:0]   n_vout;
    logic [LW-1:0] r_pout;
    logic [LW-1:0] n_pout;

    // result register
    logic          r_out_valid;
    t_status       r_o_status;
    logic [31:0]   r_o_vout;
    logic [LW-1:0] r_o_pout;
    logic [LW-1:0] r_o_len;

    // sequencer handshake
    t_uword        uw;
    t_flags        flags;
    logic          busy;
    logic          start;
    logic          stall;
    logic          active;
    logic          commit;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    assign start      = i_in_valid && o_in_ready;
    assign o_in_ready = !busy;
    // a finished request waits in its last step while the result beat is still pending
    assign stall      = uw.done && r_out_valid && !i_out_ready;
    assign active     = busy && !stall;
    assign commit     = active && uw.done;

    assign idx_m1 = r_idx - 1'b1;
    assign idx_p1 = r_idx + 1'b1;

    // branch conditions seen by the sequencer
    always_comb begin
        flags.pos_gt_len    = r_pos > PW'(r_len);
        flags.pos_ge_len    = r_pos >= PW'(r_len);
        flags.len_full      = r_len >= LW'(DEPTH);
        flags.idx_le_pos    = PW'(r_idx) <= r_pos;
        flags.idx_p1_ge_len = idx_p1 >= r_len;
        flags.idx_ge_len    = r_idx >= r_len;
        flags.match         = r_rdata == r_val;
        flags.idx_zero      = r_idx == '0;
        flags.op_locate     = r_op == OP_LOCATE;
        flags.op_next       = r_op == OP_NEXT;
    end

    sle_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stall (stall),
        .i_flags (flags),
        .o_uword (uw),
        .o_busy  (busy)
    );

    // memory read port address
    always_comb begin
        rd_en = active && (uw.rd != RD_NONE);
        unique case (uw.rd)
            RD_IDX:    rd_addr = r_idx[AW-1:0];
            RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
            RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
            RD_POS:    rd_addr = r_pos[AW-1:0];
            default:   rd_addr = r_idx[AW-1:0];
        endcase
    end

    // memory write port: shifted element or the new element
    always_comb begin
        wr_en = active && (uw.wr != WR_NONE);
        unique case (uw.wr)
            WR_POS_VAL: begin
                wr_addr = r_pos[AW-1:0];
                wr_data = r_val;
            end
            default: begin
                wr_addr = r_idx[AW-1:0];
                wr_data = r_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // index register update
    always_comb begin
        n_idx = r_idx;
        if (active) begin
            unique case (uw.idx)
                IDX_LEN:  n_idx = r_len;
                IDX_POS:  n_idx = LW'(r_pos);
                IDX_ZERO: n_idx = '0;
                IDX_INC:  n_idx = idx_p1;
                IDX_DEC:  n_idx = idx_m1;
                default:  n_idx = r_idx;
            endcase
        end
    end

    // length and result field updates; the last step's action lands in the same beat
    always_comb begin
        n_len    = r_len;
        n_status = r_status;
        n_vout   = r_vout;
        n_pout   = r_pout;
        if (active) begin
            unique case (uw.act)
                ACT_LEN_CLR: n_len    = '0;
                ACT_LEN_INC: n_len    = r_len + 1'b1;
                ACT_LEN_DEC: n_len    = r_len - 1'b1;
                ACT_VOUT:    n_vout   = r_rdata;
                ACT_POUT:    n_pout   = r_idx;
                ACT_STATUS:  n_status = uw.status;
                default:     n_len    = r_len;
            endcase
        end
    end

    // request capture and working registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op     <= i_op;
            r_pos    <= PW'(i_position_in);
            r_val    <= i_value_in;
            r_status <= STAT_OK;
            r_vout   <= '0;
            r_pout   <= '0;
        end else begin
            r_status <= n_status;
            r_vout   <= n_vout;
            r_pout   <= n_pout;
        end
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    // result register: loaded on the final step, held until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_o_status <= n_status;
            r_o_vout   <= n_vout;
            r_o_pout   <= n_pout;
            r_o_len    <= n_len;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_value_out       = $signed(r_o_vout);
    assign o_position_out    = 6'(r_o_pout);
    assign o_list_length_out = 7'(r_o_len);
    assign o_is_empty        = r_o_len == '0;

    // the list never grows past its capacity
    `SLE_ASSERT_NOW(a_len_cap, i_clk, i_rst_n, 1'b1, r_len <= LW'(DEPTH))
    // a taken request keeps the sequencer busy in the following cycle
    `SLE_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start, busy)
    // a fresh result beat appears only as the sequencer finishes
    `SLE_ASSERT_NOW(a_out_on_done, i_clk, i_rst_n, $rose(r_out_valid), $fell(busy))
    // a stalled final step must not apply its length change
    `SLE_ASSERT_NEXT(a_stall_len, i_clk, i_rst_n, stall, $stable(r_len))

endmodule

FILE: sv/sle_seq.sv
// microcode sequencer: step counter, control store and branch select
module sle_seq
    import sle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_op,
    input  logic       i_stall,
    input  t_flags     i_flags,
    output t_uword     o_uword,
    output logic       o_busy
);

    t_step r_step;
    t_step n_step;
    logic  r_busy;
    logic  n_busy;
    logic  cond_true;

    assign o_uword = uprog(r_step);
    assign o_busy  = r_busy;

    always_comb begin
        unique case (o_uword.cond)
            C_NEXT:          cond_true = 1'b0;
            C_ALWAYS:        cond_true = 1'b1;
            C_POS_GT_LEN:    cond_true = i_flags.pos_gt_len;
            C_POS_GE_LEN:    cond_true = i_flags.pos_ge_len;
            C_LEN_FULL:      cond_true = i_flags.len_full;
            C_IDX_LE_POS:    cond_true = i_flags.idx_le_pos;
            C_IDX_P1_GE_LEN: cond_true = i_flags.idx_p1_ge_len;
            C_IDX_GE_LEN:    cond_true = i_flags.idx_ge_len;
            C_MATCH:         cond_true = i_flags.match;
            C_IDX_ZERO:      cond_true = i_flags.idx_zero;
            C_OP_LOCATE:     cond_true = i_flags.op_locate;
            C_OP_NEXT:       cond_true = i_flags.op_next;
            default:         cond_true = 1'b0;
        endcase
    end

    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        if (i_start) begin
            n_step = entry_step(i_op);
            n_busy = 1'b1;
        end else if (r_busy && !i_stall) begin
            priority if (o_uword.done) begin
                n_busy = 1'b0;
            end else if (cond_true) begin
                n_step = o_uword.target;
            end else begin
                n_step = t_step'(r_step + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLEAR;
            r_busy <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
        end
    end

endmodule

FILE: bench/tb_sequential_list_engine_core.sv
// testbench for the sequential list engine: directed edge cases, capacity and random traffic
`timescale 1ns / 1ps

module tb_sequential_list_engine_core
    import sle_pkg::*;
();

    localparam int         LIST_DEPTH    = 64;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         SETTLE_CYCLES = 250;
    localparam logic [2:0] OP_UNDEFINED  = 3'd7;

    typedef struct {
        t_status            status;
        logic signed [31:0] value;
        logic [5:0]         position;
        logic [6:0]         length;
        logic               empty;
    } t_list_result;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         req_op;
    logic [6:0]         req_position;
    logic signed [31:0] req_value;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         res_status;
    logic signed [31:0] res_value;
    logic [5:0]         res_position;
    logic [6:0]         res_length;
    logic               res_empty;

    // shadow copy of the list contents, position 0 first
    logic signed [31:0] shadow_list[$];
    t_list_result       expected_results[$];

    int  error_count = 0;
    int  results_checked = 0;
    int  stall_cycles = 0;
    int  ops_seen[8];
    int  status_seen[8];
    bit  sender_steady = 1'b0;
    bit  sink_steady = 1'b0;

    sequential_list_engine_core #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_op              (req_op),
        .i_position_in     (req_position),
        .i_value_in        (req_value),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (res_status),
        .o_value_out       (res_value),
        .o_position_out    (res_position),
        .o_list_length_out (res_length),
        .o_is_empty        (res_empty)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // apply one request to the shadow list and work out the result beat it must produce
    function automatic t_list_result apply_list_request(input logic [2:0] op,
                                                        input logic [6:0] pos,
                                                        input logic signed [31:0] val);
        t_list_result r;
        int           hit;
        r.status   = STAT_OK;
        r.value    = '0;
        r.position = '0;
        hit        = -1;
        case (op)
            OP_CLEAR: begin
                shadow_list.delete();
            end
            OP_INSERT: begin
                if (pos > shadow_list.size())
                    r.status = STAT_BAD_POS;
                else if (shadow_list.size() >= LIST_DEPTH)
                    r.status = STAT_FULL;
                else
                    shadow_list.insert(pos, val);
            end
            OP_DELETE: begin
                if (pos >= shadow_list.size()) begin
                    r.status = STAT_BAD_POS;
                end else begin
                    r.value = shadow_list[pos];
                    shadow_list.delete(pos);
                end
            end
            OP_READ: begin
                if (pos >= shadow_list.size())
                    r.status = STAT_BAD_POS;
                else
                    r.value = shadow_list[pos];
            end
            OP_LOCATE, OP_PRIOR, OP_NEXT: begin
                // searches always take the lowest matching position
                for (int k = 0; k < shadow_list.size(); k++) begin
                    if (shadow_list[k] == val) begin
                        hit = k;
                        break;
                    end
                end
                if (hit < 0)
                    r.status = STAT_NOT_FOUND;
                else if (op == OP_LOCATE)
                    r.position = 6'(hit);
                else if (op == OP_PRIOR && hit == 0)
                    r.status = STAT_NO_NEIGHBOUR;
                else if (op == OP_PRIOR)
                    r.value = shadow_list[hit - 1];
                else if (hit + 1 >= shadow_list.size())
                    r.status = STAT_NO_NEIGHBOUR;
                else
                    r.value = shadow_list[hit + 1];
            end
            default: ;
        endcase
        r.length = 7'(shadow_list.size());
        r.empty  = (shadow_list.size() == 0);
        return r;
    endfunction

    // present one request beat and hold it until taken
    task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
                                input logic signed [31:0] val);
        int           gap;
        t_list_result want;
        if ($urandom_range(0, 39) == 0)
            sender_steady = !sender_steady;
        gap = sender_steady ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_op       <= op;
        req_position <= pos;
        req_value    <= val;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!in_ready);
        want = apply_list_request(op, pos, val);
        expected_results.push_back(want);
        ops_seen[op]++;
        status_seen[want.status]++;
    endtask

    // hold the request side off until every outstanding result has been taken
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic test_directed_edges();
        // empty list: read, delete and insert past the end are out of range and nothing can be found
        send_request(OP_READ, 7'd0, 32'sd0);
        send_request(OP_DELETE, 7'd0, 32'sd0);
        send_request(OP_LOCATE, 7'd0, 32'sd5);
        send_request(OP_PRIOR, 7'd0, 32'sd5);
        send_request(OP_NEXT, 7'd0, 32'sd5);
        send_request(OP_INSERT, 7'd1, 32'sd9);
        // build max, 0, 0, min, -1 using head, append and middle inserts
        send_request(OP_INSERT, 7'd0, 32'sh7fffffff);
        send_request(OP_INSERT, 7'd1, 32'sh80000000);
        send_request(OP_INSERT, 7'd1, 32'sd0);
        send_request(OP_INSERT, 7'd3, -32'sd1);
        send_request(OP_INSERT, 7'd1, 32'sd0);
        send_request(OP_READ, 7'd4, 32'sd0);
        send_request(OP_READ, 7'd5, 32'sd0);
        send_request(OP_READ, 7'd127, -32'sd1);
        // duplicate zeros: lowest match wins
        send_request(OP_LOCATE, 7'd0, 32'sd0);
        send_request(OP_PRIOR, 7'd0, 32'sh7fffffff);
        send_request(OP_NEXT, 7'd0, -32'sd1);
        send_request(OP_PRIOR, 7'd0, 32'sd0);
        send_request(OP_NEXT, 7'd0, 32'sd0);
        send_request(OP_UNDEFINED, 7'd127, -32'sd1);
        send_request(OP_DELETE, 7'd0, 32'sd0);
        send_request(OP_DELETE, 7'd127, 32'sd0);
        send_request(OP_LOCATE, 7'd0, 32'sh80000000);
        send_request(OP_CLEAR, 7'd0, 32'sd0);
        send_request(OP_READ, 7'd0, 32'sd0);
    endtask

    task automatic test_capacity();
        logic signed [31:0] last_value;
        // distinct values so the tail element is found at the top position
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if (k % 4 == 3)
                send_request(OP_INSERT, 7'($urandom_range(0, shadow_list.size())),
                             32'h5a5a0000 | 32'(k));
            else
                send_request(OP_INSERT, 7'(shadow_list.size()), 32'h5a5a0000 | 32'(k));
        end
        last_value = shadow_list[LIST_DEPTH - 1];
        // position check comes before the full check
        send_request(OP_INSERT, 7'(LIST_DEPTH + 1), 32'sd1);
        send_request(OP_INSERT, 7'(LIST_DEPTH), 32'sd1);
        send_request(OP_INSERT, 7'd0, 32'sd1);
        send_request(OP_LOCATE, 7'd0, last_value);
        send_request(OP_NEXT, 7'd0, last_value);
        send_request(OP_PRIOR, 7'd0, last_value);
        send_request(OP_LOCATE, 7'd0, -32'sd7);
        send_request(OP_READ, 7'(LIST_DEPTH - 1), 32'sd0);
        send_request(OP_READ, 7'(LIST_DEPTH), 32'sd0);
        send_request(OP_DELETE, 7'(LIST_DEPTH - 1), 32'sd0);
        send_request(OP_DELETE, 7'd0, 32'sd0);
        send_request(OP_CLEAR, 7'd0, 32'sd0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int                 trend;
        int                 pick;
        int                 len;
        int                 ins_share;
        int                 del_share;
        logic [2:0]         op;
        logic [6:0]         pos;
        logic signed [31:0] val;
        trend = 1;
        for (int i = 0; i < n_items; i++) begin
            // grow, balanced or shrink phases so the list visits both empty and full
            if (i % 100 == 0)
                trend = $urandom_range(0, 2);
            ins_share = (trend == 0) ? 55 : (trend == 1) ? 30 : 12;
            del_share = (trend == 0) ? 12 : (trend == 1) ? 30 : 55;
            len  = shadow_list.size();
            pick = $urandom_range(0, 99);
            if (pick < 1)
                op = OP_CLEAR;
            else if (pick < 3)
                op = OP_UNDEFINED;
            else if (pick < 3 + ins_share)
                op = OP_INSERT;
            else if (pick < 3 + ins_share + del_share)
                op = OP_DELETE;
            else
                op = 3'($urandom_range(3, 6));

            if ($urandom_range(0, 9) == 0)
                pos = 7'($urandom_range(0, 127));
            else if (op == OP_INSERT)
                pos = 7'($urandom_range(0, len));
            else
                pos = (len == 0) ? 7'd0 : 7'($urandom_range(0, len - 1));

            // searches mostly look for something that is there
            if ((op == OP_LOCATE || op == OP_PRIOR || op == OP_NEXT) && len != 0 &&
                $urandom_range(0, 3) != 0)
                val = shadow_list[$urandom_range(0, len - 1)];
            else if ($urandom_range(0, 1) == 1)
                val = 32'($urandom_range(0, 15)) - 32'sd8;
            else
                val = $urandom;

            send_request(op, pos, val);
            if ($urandom_range(0, 199) == 0)
                wait_for_results();
        end
    endtask

    // result sink with random back-pressure
    initial begin : result_sink
        int gap;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                sink_steady = !sink_steady;
            gap = sink_steady ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare every result beat with the oldest expectation
    always @(posedge clk) begin : result_check
        t_list_result want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no request outstanding");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (res_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_status);
                    error_count++;
                end
                if (res_value !== want.value) begin
                    $error("value_out: expected %0d, got %0d", want.value, res_value);
                    error_count++;
                end
                if (res_position !== want.position) begin
                    $error("position_out: expected %0d, got %0d", want.position, res_position);
                    error_count++;
                end
                if (res_length !== want.length) begin
                    $error("list_length_out: expected %0d, got %0d", want.length, res_length);
                    error_count++;
                end
                if (res_empty !== want.empty) begin
                    $error("is_empty: expected %0d, got %0d", want.empty, res_empty);
                    error_count++;
                end
            end
        end
    end

    // give up when no beat moves on either side for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        req_op       <= OP_CLEAR;
        req_position <= '0;
        req_value    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        wait_for_results();
        test_capacity();
        wait_for_results();
        test_random_traffic(1250);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end
        $display("covered %0d requests: clear %0d insert %0d delete %0d read %0d locate %0d",
                 ops_seen.sum(), ops_seen[OP_CLEAR], ops_seen[OP_INSERT], ops_seen[OP_DELETE],
                 ops_seen[OP_READ], ops_seen[OP_LOCATE]);
        $display("prior %0d next %0d undefined %0d; %0d results checked, %0d full, %0d errors",
                 ops_seen[OP_PRIOR], ops_seen[OP_NEXT], ops_seen[OP_UNDEFINED],
                 results_checked, status_seen[STAT_FULL], error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/sle_pkg.sv
sv/sle_seq.sv
sv/sequential_list_engine_core.sv
bench/tb_sequential_list_engine_core.sv
